[sv/ucd_pkg.sv]
package ucd_pkg;

   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam int unsigned GroupMax = 3;

   typedef logic [1:0] grp_cnt_type;

   typedef struct packed {
      grp_cnt_type           cnt;
      logic [2:0][7:0]       bytes;
      logic                  last;
   } ucd_group_type;

   function automatic logic is_hex(input logic [7:0] c);
      logic r;
      r = (c >= 8'd48 && c <= 8'd57) || (c >= 8'd97 && c <= 8'd102)
          || (c >= 8'd65 && c <= 8'd70);
      return r;
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [3:0] r;
      if (c <= 8'd57) begin
         r = c[3:0];
      end else begin
         r = c[3:0] + 4'd9;
      end
      return r;
   endfunction

   function automatic logic is_safe(input logic [7:0] v);
      logic r;
      r = (v >= 8'd48 && v <= 8'd57) || (v >= 8'd97 && v <= 8'd122)
          || (v >= 8'd65 && v <= 8'd90) || v == 8'h21 || v == 8'h24
          || (v >= 8'h26 && v <= 8'h2f) || v == 8'h3A || v == 8'h3B
          || v == 8'h3D || v == 8'h3f || v == 8'h40 || v == 8'h5f;
      return r;
   endfunction

endpackage

[sv/ucd_decode.sv]
module ucd_decode (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             in_byte,
   input  logic                   in_last,
   output ucd_pkg::ucd_group_type grp
);
   import ucd_pkg::*;

   localparam logic [1:0] LVL_IDLE  = 2'd0;
   localparam logic [1:0] LVL_PCT   = 2'd1;
   localparam logic [1:0] LVL_DIGIT = 2'd2;

   logic [1:0] lvl_ff;
   logic [1:0] lvl_in;
   logic [7:0] held_ff;
   logic [7:0] held_in;

   always_comb begin
      logic [1:0]      cnt;
      logic [1:0]      nlvl;
      logic [7:0]      nheld;
      logic [2:0][7:0] bytes;
      logic            f_pct;
      logic [7:0]      f_byte;
      logic            b_hex;
      logic [7:0]      val;

      cnt    = 2'd0;
      nlvl   = LVL_IDLE;
      nheld  = held_ff;
      bytes  = '0;
      f_pct  = (in_byte == CH_PCT);
      f_byte = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
      b_hex  = is_hex(in_byte);
      val    = {hex_val(held_ff), hex_val(in_byte)};

      unique case (lvl_ff)
         LVL_PCT: begin
            if (b_hex) begin
               nlvl  = LVL_DIGIT;
               nheld = in_byte;
            end else begin
               bytes[0] = CH_PCT;
               if (f_pct) begin
                  nlvl = LVL_PCT;
                  cnt  = 2'd1;
               end else begin
                  bytes[1] = f_byte;
                  cnt      = 2'd2;
               end
            end
         end
         LVL_DIGIT: begin
            nheld = 8'd0;
            if (b_hex) begin
               if (!is_safe(val)) begin
                  bytes[0] = val;
                  cnt      = 2'd1;
               end else begin
                  bytes[0] = CH_PCT;
                  bytes[1] = held_ff;
                  bytes[2] = in_byte;
                  cnt      = 2'd3;
               end
            end else begin
               bytes[0] = CH_PCT;
               bytes[1] = held_ff;
               if (f_pct) begin
                  nlvl = LVL_PCT;
                  cnt  = 2'd2;
               end else begin
                  bytes[2] = f_byte;
                  cnt      = 2'd3;
               end
            end
         end
         default: begin
            if (f_pct) begin
               nlvl = LVL_PCT;
            end else begin
               bytes[0] = f_byte;
               cnt      = 2'd1;
            end
         end
      endcase

      if (in_last) begin
         if (nlvl == LVL_PCT) begin
            case (cnt)
               2'd0:    bytes[0] = CH_PCT;
               2'd1:    bytes[1] = CH_PCT;
               default: bytes[2] = CH_PCT;
            endcase
            cnt = cnt + 2'd1;
         end else if (nlvl == LVL_DIGIT) begin
            bytes[0] = CH_PCT;
            bytes[1] = nheld;
            cnt      = 2'd2;
         end
         nlvl  = LVL_IDLE;
         nheld = 8'd0;
      end

      grp.cnt   = cnt;
      grp.bytes = bytes;
      grp.last  = in_last;
      lvl_in    = nlvl;
      held_in   = nheld;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lvl_ff  <= LVL_IDLE;
         held_ff <= 8'd0;
      end else if (step) begin
         lvl_ff  <= lvl_in;
         held_ff <= held_in;
      end
   end

`ifndef SYNTHESIS
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      step && in_last |=> lvl_ff == LVL_IDLE)
      else $error("pending level not cleared after end of text");
   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      step && in_last |-> grp.cnt != 2'd0)
      else $error("end of text produced no result");
   a_digit_from_pct: assert property (@(posedge clock) disable iff (reset)
      $past(step) && lvl_ff == LVL_DIGIT |-> $past(lvl_ff) == LVL_PCT)
      else $error("held digit without a preceding percent sign");
`endif

endmodule

[sv/ucd_emit.sv]
module ucd_emit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  ucd_pkg::ucd_group_type grp,
   output logic                   free,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_out_last
);
   import ucd_pkg::*;

   grp_cnt_type     cnt_ff;
   grp_cnt_type     cnt_in;
   logic [2:0][7:0] byte_ff;
   logic [2:0][7:0] byte_in;
   logic [2:0]      lastv_ff;
   logic [2:0]      lastv_in;
   logic            take;

   assign rsp_valid    = (cnt_ff != 2'd0);
   assign rsp_out_byte = byte_ff[0];
   assign rsp_out_last = lastv_ff[0];
   assign take         = rsp_valid && !rsp_stall;
   assign free         = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && !rsp_stall);

   always_comb begin
      cnt_in   = cnt_ff;
      byte_in  = byte_ff;
      lastv_in = lastv_ff;
      if (load) begin
         cnt_in  = grp.cnt;
         byte_in = grp.bytes;
         for (int i = 0; i < GroupMax; i++) begin
            lastv_in[i] = grp.last && (grp.cnt == grp_cnt_type'(i + 1));
         end
      end else if (take) begin
         cnt_in   = cnt_ff - 2'd1;
         byte_in  = {8'd0, byte_ff[2], byte_ff[1]};
         lastv_in = {1'b0, lastv_ff[2], lastv_ff[1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      byte_ff  <= byte_in;
      lastv_ff <= lastv_in;
   end

`ifndef SYNTHESIS
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("group loaded while results were still pending");
   a_last_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_last |-> cnt_ff == 2'd1)
      else $error("last flag on a beat that is not the final one");
`endif

endmodule

[sv/url_percent_decoder_core.sv]
// The input beat is first registered in the input stage and then loaded, once the result
// register is free, into the result register that offers the first result beat.
// Throughput: one input beat per cycle while each beat yields at most one result and
// the output does not stall. A beat that yields two or three results holds the input
// while the result register drains the group down to its last result beat.
// Reset is synchronous and active high; it clears the valid flags and the pending state.
module url_percent_decoder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);
   import ucd_pkg::*;

   logic          a_valid_ff;
   logic          a_valid_in;
   logic [7:0]    a_byte_ff;
   logic          a_last_ff;
   logic          free;
   logic          a_move;
   ucd_group_type grp;

   assign a_move     = a_valid_ff && free;
   assign req_stall  = a_valid_ff && !free;
   assign a_valid_in = req_stall ? 1'b1 : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
      if (req_valid && !req_stall) begin
         a_byte_ff <= req_in_byte;
         a_last_ff <= req_in_last;
      end
   end

   ucd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .step    (a_move),
      .in_byte (a_byte_ff),
      .in_last (a_last_ff),
      .grp     (grp)
   );

   ucd_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .load         (a_move),
      .grp          (grp),
      .free         (free),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule
